[hw/rtl/assert_macros.svh]
// Assertion macros shared by the line generator modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LPG_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("line generator assertion failed");
`define LPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line generator assertion failed");
`else
`define LPG_ASSERT(lbl, expr)
`define LPG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/lpg_pkg.sv]
`default_nettype none
package lpg_pkg;

    localparam int COORD_W        = 6;
    localparam int REG_W          = 7;
    localparam int ADDR_W         = 12;
    localparam int ERR_W          = 9;
    localparam int OUT_COLOR_BITS = 24;
    localparam int COLOR_BITS_DEF = 24;
    localparam int QUEUE_DEPTH    = 2;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [REG_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 7'd64;

    // Register index as decoded from paddr[2].
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // One classified line, ready for the stepper.
    typedef struct packed {
        logic                    steep;
        logic                    neg_major;
        logic                    neg_minor;
        logic [COORD_W-1:0]      major_pos;
        logic [COORD_W-1:0]      minor_pos;
        logic [COORD_W-1:0]      major_delta;
        logic [COORD_W-1:0]      minor_delta;
        logic signed [ERR_W-1:0] err_init;
    } t_line_cmd;

endpackage
`default_nettype wire

[hw/rtl/line_pixel_generator_unit.sv]
// Bresenham line rasterizer: one line command in, one pixel beat per major-axis step out.
// The first pixel of a line passes through the command queue, the stepper's registers
// and its output register. A line of length n (n = 1..63) gives n pixels, one per cycle
// while i_stall is low; the stepper loads a command only when idle, and a two-entry
// command queue decouples input from stepping; zero-length lines emit nothing.
// Reset (synchronous, active low): queue empty, stepper idle, width and height set to 64.
`default_nettype none
module line_pixel_generator_unit
    import lpg_pkg::*;
#(
    parameter int COLOR_BITS = COLOR_BITS_DEF,
    parameter int Q_DEPTH    = QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,

    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [COLOR_BITS-1:0] i_line_color,
    input  wire logic [COORD_W-1:0]    i_start_x,
    input  wire logic [COORD_W-1:0]    i_start_y,
    input  wire logic [COORD_W-1:0]    i_end_x,
    input  wire logic [COORD_W-1:0]    i_end_y,

    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [COORD_W-1:0]         o_pixel_x,
    output logic [COORD_W-1:0]         o_pixel_y,
    output logic [ADDR_W-1:0]          o_pixel_address,
    output logic [COLOR_BITS-1:0]      o_pixel_color,
    output logic                       o_visible,
    output logic                       o_last_pixel
);

    localparam int CMD_W = $bits(t_line_cmd);
    localparam int Q_W   = CMD_W + COLOR_BITS;

    logic [REG_W-1:0]      r_image_width;
    logic [REG_W-1:0]      r_image_height;
    logic                  cfg_write;

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_valid;
    t_line_cmd             front_cmd;
    logic [COLOR_BITS-1:0] front_color;
    logic [Q_W-1:0]        q_in;
    logic [Q_W-1:0]        q_out;
    t_line_cmd             step_cmd;
    logic [COLOR_BITS-1:0] step_color;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[REG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[REG_W-1:0];
                default:          r_image_width  <= r_image_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_image_height);
            default:          prdata = '0;
        endcase
    end

    lpg_front #(
        .COLOR_BITS (COLOR_BITS)
    ) u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_line_color (i_line_color),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_cmd        (front_cmd),
        .o_color      (front_color)
    );

    assign q_in       = {front_color, front_cmd};
    assign step_cmd   = q_out[CMD_W-1:0];
    assign step_color = q_out[Q_W-1:CMD_W];

    lpg_queue #(
        .DATA_W (Q_W),
        .DEPTH  (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    lpg_stepper #(
        .COLOR_BITS (COLOR_BITS)
    ) u_stepper (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_image_width   (r_image_width),
        .i_image_height  (r_image_height),
        .i_q_valid       (q_valid),
        .i_cmd           (step_cmd),
        .i_color         (step_color),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_visible       (o_visible),
        .o_last_pixel    (o_last_pixel)
    );

endmodule
`default_nettype wire

[hw/rtl/lpg_front.sv]
`default_nettype none
module lpg_front
    import lpg_pkg::*;
#(
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [COLOR_BITS-1:0] i_line_color,
    input  wire logic [COORD_W-1:0]    i_start_x,
    input  wire logic [COORD_W-1:0]    i_start_y,
    input  wire logic [COORD_W-1:0]    i_end_x,
    input  wire logic [COORD_W-1:0]    i_end_y,
    input  wire logic                  i_queue_full,
    output logic                       o_push,
    output t_line_cmd                  o_cmd,
    output logic [COLOR_BITS-1:0]      o_color
);

    logic               pos_x;
    logic               pos_y;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               steep;

    always_comb begin
        pos_x = i_end_x > i_start_x;
        pos_y = i_end_y > i_start_y;
        dx    = pos_x ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
        dy    = pos_y ? (i_end_y - i_start_y) : (i_start_y - i_end_y);
        steep = dy > dx;

        o_cmd.steep = steep;
        if (steep) begin
            o_cmd.neg_major   = !pos_y;
            o_cmd.neg_minor   = !pos_x;
            o_cmd.major_pos   = i_start_y;
            o_cmd.minor_pos   = i_start_x;
            o_cmd.major_delta = dy;
            o_cmd.minor_delta = dx;
        end else begin
            o_cmd.neg_major   = !pos_x;
            o_cmd.neg_minor   = !pos_y;
            o_cmd.major_pos   = i_start_x;
            o_cmd.minor_pos   = i_start_y;
            o_cmd.major_delta = dx;
            o_cmd.minor_delta = dy;
        end
        o_cmd.err_init = $signed({2'b00, o_cmd.minor_delta, 1'b0})
                       - $signed({3'b000, o_cmd.major_delta});

        // Colour bits above the packed RGB word always read as zero.
        for (int b = 0; b < COLOR_BITS; b++) begin
            o_color[b] = (b < OUT_COLOR_BITS) ? i_line_color[b] : 1'b0;
        end
    end

    assign o_stall = i_queue_full;
    // Zero-length lines produce no pixels and are dropped here.
    assign o_push  = i_valid && !i_queue_full && (o_cmd.major_delta != '0);

endmodule
`default_nettype wire

[hw/rtl/lpg_queue.sv]
`default_nettype none
`include "assert_macros.svh"
module lpg_queue
    import lpg_pkg::*;
#(
    parameter int DATA_W = 32,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    `LPG_ASSERT(q_no_overflow, !(i_push && !i_pop && o_full))
    `LPG_ASSERT(q_no_underflow, !(i_pop && !o_valid))
    `LPG_ASSERT(q_count_bound, r_count <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

[hw/rtl/lpg_stepper.sv]
`default_nettype none
`include "assert_macros.svh"
module lpg_stepper
    import lpg_pkg::*;
#(
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [REG_W-1:0]      i_image_width,
    input  wire logic [REG_W-1:0]      i_image_height,
    input  wire logic                  i_q_valid,
    input  wire t_line_cmd             i_cmd,
    input  wire logic [COLOR_BITS-1:0] i_color,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [COORD_W-1:0]         o_pixel_x,
    output logic [COORD_W-1:0]         o_pixel_y,
    output logic [ADDR_W-1:0]          o_pixel_address,
    output logic [COLOR_BITS-1:0]      o_pixel_color,
    output logic                       o_visible,
    output logic                       o_last_pixel
);

    localparam int PROD_W = REG_W + COORD_W + 1;

    // Line walker state.
    logic                    r_busy;
    logic [COORD_W-1:0]      r_steps_left;
    logic                    r_steep;
    logic                    r_neg_major;
    logic                    r_neg_minor;
    logic [COORD_W-1:0]      r_major_pos;
    logic [COORD_W-1:0]      r_minor_pos;
    logic [COORD_W-1:0]      r_major_delta;
    logic [COORD_W-1:0]      r_minor_delta;
    logic signed [ERR_W-1:0] r_err;
    logic [COLOR_BITS-1:0]   r_color;

    // Output register.
    logic                    r_out_valid;
    logic [COORD_W-1:0]      r_pixel_x;
    logic [COORD_W-1:0]      r_pixel_y;
    logic [ADDR_W-1:0]       r_pixel_address;
    logic [COLOR_BITS-1:0]   r_pixel_color;
    logic                    r_visible;
    logic                    r_last_pixel;

    logic                    advance;
    logic                    load;
    logic [COORD_W-1:0]      cur_x;
    logic [COORD_W-1:0]      cur_y;
    logic                    cur_vis;
    logic [PROD_W-1:0]       cur_addr;
    logic signed [ERR_W-1:0] n_err;
    logic [COORD_W-1:0]      n_major_pos;
    logic [COORD_W-1:0]      n_minor_pos;

    always_comb begin
        advance  = r_busy && (!r_out_valid || !i_stall);
        load     = !r_busy && i_q_valid;
        cur_x    = r_steep ? r_minor_pos : r_major_pos;
        cur_y    = r_steep ? r_major_pos : r_minor_pos;
        cur_vis  = ({1'b0, cur_x} < i_image_width) && ({1'b0, cur_y} < i_image_height);
        cur_addr = PROD_W'(i_image_width) * PROD_W'(cur_y) + PROD_W'(cur_x);

        n_major_pos = r_neg_major ? r_major_pos - 1'b1 : r_major_pos + 1'b1;
        n_minor_pos = r_minor_pos;
        n_err       = r_err + $signed({2'b00, r_minor_delta, 1'b0});
        // A non-negative error moves the minor axis by one and pays it back.
        if (!r_err[ERR_W-1]) begin
            n_minor_pos = r_neg_minor ? r_minor_pos - 1'b1 : r_minor_pos + 1'b1;
            n_err       = n_err - $signed({2'b00, r_major_delta, 1'b0});
        end
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (advance && r_steps_left == COORD_W'(1)) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_steps_left  <= i_cmd.major_delta;
            r_steep       <= i_cmd.steep;
            r_neg_major   <= i_cmd.neg_major;
            r_neg_minor   <= i_cmd.neg_minor;
            r_major_pos   <= i_cmd.major_pos;
            r_minor_pos   <= i_cmd.minor_pos;
            r_major_delta <= i_cmd.major_delta;
            r_minor_delta <= i_cmd.minor_delta;
            r_err         <= i_cmd.err_init;
            r_color       <= i_color;
        end else if (advance) begin
            r_steps_left <= r_steps_left - 1'b1;
            r_major_pos  <= n_major_pos;
            r_minor_pos  <= n_minor_pos;
            r_err        <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pixel_x       <= cur_x;
            r_pixel_y       <= cur_y;
            r_pixel_address <= cur_vis ? cur_addr[ADDR_W-1:0] : '0;
            r_pixel_color   <= r_color;
            r_visible       <= cur_vis;
            r_last_pixel    <= r_steps_left == COORD_W'(1);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_x       = r_pixel_x;
    assign o_pixel_y       = r_pixel_y;
    assign o_pixel_address = r_pixel_address;
    assign o_pixel_color   = r_pixel_color;
    assign o_visible       = r_visible;
    assign o_last_pixel    = r_last_pixel;

    `LPG_ASSERT(stp_busy_has_steps, !r_busy || r_steps_left != '0)
    `LPG_ASSERT_NEXT(stp_last_step_idles, advance && r_steps_left == COORD_W'(1), !r_busy)
    `LPG_ASSERT_NEXT(stp_load_starts_line, load, r_busy && r_steps_left != '0)

endmodule
`default_nettype wire
